>>> rtl/pvma_pkg.sv
// Package: shared constants, codes, controller states and the command bundle.
`timescale 1ns / 1ps
package pvma_pkg;

    localparam int unsigned DEF_MAX_ITEMS = 64;
    localparam int unsigned PV_W          = 32;
    localparam int unsigned K_BITS        = 7;
    localparam logic [PV_W-1:0] Q_ONE     = 32'h8000_0000;

    // configuration register indexes
    localparam logic CFG_IDX_ADJUST_MODE = 1'b0;
    localparam logic CFG_IDX_METHOD      = 1'b1;

    // adjust_mode codes (3 behaves as single-step)
    localparam logic [1:0] MODE_SINGLE    = 2'd0;
    localparam logic [1:0] MODE_STEP_DOWN = 2'd1;
    localparam logic [1:0] MODE_STEP_UP   = 2'd2;

    // correction_method codes
    localparam logic METH_BONFERRONI = 1'b0;
    localparam logic METH_SIDAK      = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_INS,
        S_INV,
        S_A_IDX,
        S_A_RAW,
        S_A_INIT,
        S_A_SQ,
        S_A_MU,
        S_A_SFIN,
        S_A_WR,
        S_OUT_RD,
        S_OUT_WT
    } t_state;

    typedef struct packed {
        logic load_in;   // latch saturated input value, clear position count
        logic store;     // write input value into the raw store
        logic scan_rd;   // issue a rank scan read
        logic rank_fin;  // write new item's rank
        logic inv_rd;    // issue a rank read for inverse table build
        logic raw_inv;   // raw read address taken from inverse table
        logic idx_load;  // latch item index
        logic init;      // start correction of the fetched value
        logic sq;        // square step
        logic mu;        // multiply step
        logic sidak_fin; // finish power correction
        logic wr;        // write adjusted value
        logic first;     // first value of the running pass
        logic run_max;   // step-down running maximum
        logic run_min;   // step-up running minimum
        logic out_load;  // load output register
        logic out_last;  // final result of batch
        logic out_ovf;   // batch overflowed
    } t_dp_cmd;

endpackage

>>> rtl/pvalue_multiple_test_adjust.sv
// Top level: multiple-testing p-value adjustment engine.
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: pvalue; tlast: last_item
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: adjusted_pvalue;
//                                               tlast: final_result; tuser: overflow_flag
// cfg       in   i_cfg_valid/o_cfg_ready        index 0 adjust_mode, 1 correction_method
//
// A stored item is ranked by a scan over the items already held: the rank scan
// reads one stored value per cycle through the value memory port. A dropped item
// is not stored and sets the overflow flag. On the item marked last, the inverse
// rank table is built, then each value is scaled by its order (Bonferroni) or
// takes 7 squarings and one multiply per set bit of its order (Sidak) on the
// shared multiplier, then each result is emitted. Reset is synchronous, active
// low, and clears control state only; the stores need no clearing.
// Input is taken only between items; output stalls hold the emitter.
`timescale 1ns / 1ps
module pvalue_multiple_test_adjust #(
    parameter int unsigned MAX_ITEMS = pvma_pkg::DEF_MAX_ITEMS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] pvalue
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [31:0] adjusted_pvalue
    output logic        m_axis_tlast,
    output logic        m_axis_tuser,  // [0] overflow_flag
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [1:0]  i_cfg_data
);
    import pvma_pkg::*;

    localparam int unsigned AW = $clog2(MAX_ITEMS);
    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

    t_dp_cmd       cmd;
    logic [AW-1:0] addr;
    logic [CW-1:0] k;
    logic          out_free;

    // sequencing: insertion scan, inverse rank build, correction, emission
    pvma_ctrl #(
        .MAX_ITEMS (MAX_ITEMS),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tlast  (s_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_free    (out_free),
        .o_cmd         (cmd),
        .o_addr        (addr),
        .o_k           (k)
    );

    // stores, arithmetic and the output register
    pvma_dp #(
        .MAX_ITEMS (MAX_ITEMS),
        .AW        (AW),
        .CW        (CW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_addr        (addr),
        .i_k           (k),
        .i_pvalue      (s_axis_tdata),
        .o_out_free    (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );
endmodule

>>> rtl/pvma_ctrl.sv
// Controller: sequences insertion, ranking, correction and emission.
`timescale 1ns / 1ps
module pvma_ctrl #(
    parameter int unsigned MAX_ITEMS = pvma_pkg::DEF_MAX_ITEMS,
    parameter int unsigned AW        = $clog2(MAX_ITEMS),
    parameter int unsigned CW        = $clog2(MAX_ITEMS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic              s_axis_tlast,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [1:0]        i_cfg_data,
    input  logic              i_out_free,
    output pvma_pkg::t_dp_cmd o_cmd,
    output logic [AW-1:0]     o_addr,
    output logic [CW-1:0]     o_k
);
    import pvma_pkg::*;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [CW-1:0]  r_j, n_j;
    logic [CW-1:0]  r_k, n_k;
    logic [2:0]     r_bit, n_bit;
    logic           r_drop, n_drop;
    logic           r_last, n_last;
    logic           r_first, n_first;
    logic [1:0]     r_mode;
    logic           r_meth;
    logic           ranked;
    logic [K_BITS-1:0] k_ext;

    assign o_cfg_ready = 1'b1;
    assign ranked = (r_mode == MODE_STEP_DOWN) || (r_mode == MODE_STEP_UP);
    assign k_ext  = K_BITS'(r_k);
    assign o_k    = r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SINGLE;
            r_meth <= METH_BONFERRONI;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IDX_ADJUST_MODE: r_mode <= i_cfg_data;
                CFG_IDX_METHOD:      r_meth <= i_cfg_data[0];
                default:             r_meth <= r_meth;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_last  <= 1'b0;
            r_first <= 1'b0;
            r_j     <= '0;
            r_k     <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_drop  <= n_drop;
            r_last  <= n_last;
            r_first <= n_first;
            r_j     <= n_j;
            r_k     <= n_k;
            r_bit   <= n_bit;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_drop  = r_drop;
        n_last  = r_last;
        n_first = r_first;
        n_j     = r_j;
        n_k     = r_k;
        n_bit   = r_bit;
        o_cmd   = '0;
        o_addr  = r_j[AW-1:0];
        s_axis_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                o_addr = r_cnt[AW-1:0];
                if (s_axis_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_last = s_axis_tlast;
                    n_j    = '0;
                    if (r_cnt < CW'(MAX_ITEMS)) begin
                        o_cmd.store = 1'b1;
                        n_state = S_SCAN;
                    end else begin
                        n_drop = 1'b1;
                        n_state = s_axis_tlast ? S_INV : S_IDLE;
                    end
                end
            end
            S_SCAN: begin
                if (r_j < r_cnt) begin
                    o_cmd.scan_rd = 1'b1;
                    n_j = r_j + 1'b1;
                end else begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                o_addr = r_cnt[AW-1:0];
                o_cmd.rank_fin = 1'b1;
                n_cnt = r_cnt + 1'b1;
                n_j   = '0;
                n_state = r_last ? S_INV : S_IDLE;
            end
            S_INV: begin
                if (r_j < r_cnt) begin
                    o_cmd.inv_rd = 1'b1;
                    n_j = r_j + 1'b1;
                end else begin
                    n_first = 1'b1;
                    n_j = (r_mode == MODE_STEP_UP) ? r_cnt - 1'b1 : '0;
                    n_state = S_A_IDX;
                end
            end
            S_A_IDX: begin
                n_k = ranked ? r_cnt - r_j : r_cnt;
                n_state = S_A_RAW;
            end
            S_A_RAW: begin
                o_cmd.raw_inv  = ranked;
                o_cmd.idx_load = 1'b1;
                n_state = S_A_INIT;
            end
            S_A_INIT: begin
                o_cmd.init = 1'b1;
                n_bit = 3'(K_BITS - 1);
                n_state = (r_meth == METH_SIDAK) ? S_A_SQ : S_A_WR;
            end
            S_A_SQ: begin
                o_cmd.sq = 1'b1;
                if (k_ext[r_bit]) begin
                    n_state = S_A_MU;
                end else if (r_bit == '0) begin
                    n_state = S_A_SFIN;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            S_A_MU: begin
                o_cmd.mu = 1'b1;
                if (r_bit == '0) begin
                    n_state = S_A_SFIN;
                end else begin
                    n_bit = r_bit - 1'b1;
                    n_state = S_A_SQ;
                end
            end
            S_A_SFIN: begin
                o_cmd.sidak_fin = 1'b1;
                n_state = S_A_WR;
            end
            S_A_WR: begin
                o_cmd.wr      = 1'b1;
                o_cmd.first   = r_first;
                o_cmd.run_max = (r_mode == MODE_STEP_DOWN);
                o_cmd.run_min = (r_mode == MODE_STEP_UP);
                n_first = 1'b0;
                if (r_mode == MODE_STEP_UP) begin
                    if (r_j == '0) begin
                        n_state = S_OUT_RD;
                    end else begin
                        n_j = r_j - 1'b1;
                        n_state = S_A_IDX;
                    end
                end else begin
                    if (r_j == r_cnt - 1'b1) begin
                        n_j = '0;
                        n_state = S_OUT_RD;
                    end else begin
                        n_j = r_j + 1'b1;
                        n_state = S_A_IDX;
                    end
                end
            end
            S_OUT_RD: begin
                n_state = S_OUT_WT;
            end
            S_OUT_WT: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = (r_j == r_cnt - 1'b1);
                    o_cmd.out_ovf  = r_drop;
                    if (r_j == r_cnt - 1'b1) begin
                        n_cnt  = '0;
                        n_drop = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_j = r_j + 1'b1;
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_ITEMS)) else $error("item count beyond capacity");
    a_k_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_WR) |-> (r_k != '0)) else $error("correction order zero");
    a_batch_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_load && o_cmd.out_last) |=> (r_state == S_IDLE && r_cnt == '0
            && !r_drop)) else $error("batch state not cleared");
    a_batch_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_IDX) |-> (r_cnt != '0)) else $error("empty batch adjusted");
endmodule

>>> rtl/pvma_dp.sv
// Datapath: value, rank, inverse rank and result stores, multipliers and output register.
`timescale 1ns / 1ps
module pvma_dp #(
    parameter int unsigned MAX_ITEMS = pvma_pkg::DEF_MAX_ITEMS,
    parameter int unsigned AW        = $clog2(MAX_ITEMS),
    parameter int unsigned CW        = $clog2(MAX_ITEMS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pvma_pkg::t_dp_cmd i_cmd,
    input  logic [AW-1:0]     i_addr,
    input  logic [CW-1:0]     i_k,
    input  logic [31:0]       i_pvalue,
    output logic              o_out_free,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,
    output logic              m_axis_tlast,
    output logic              m_axis_tuser
);
    import pvma_pkg::*;

    localparam int unsigned BW = PV_W + CW;

    logic [PV_W-1:0] mem_raw [MAX_ITEMS];
    logic [AW-1:0]   mem_rank [MAX_ITEMS];
    logic [AW-1:0]   mem_inv [MAX_ITEMS];
    logic [PV_W-1:0] mem_adj [MAX_ITEMS];

    logic [PV_W-1:0] r_raw_rd, r_adj_rd;
    logic [AW-1:0]   r_rank_rd, r_inv_rd;
    logic [PV_W-1:0] r_p, r_q, r_r, r_v, r_prev;
    logic [AW:0]     r_pos;
    logic            r_scan_vld, r_inv_vld;
    logic [AW-1:0]   r_scan_addr, r_inv_addr, r_idx;
    logic            r_out_vld;

    logic [PV_W-1:0] p_sat;
    logic [AW-1:0]   raw_addr;
    logic [2*PV_W-1:0] prod;
    logic [BW-1:0]   bonf;
    logic [PV_W-1:0] bonf_sat, v_run;

    assign p_sat    = (i_pvalue > Q_ONE) ? Q_ONE : i_pvalue;
    assign raw_addr = i_cmd.raw_inv ? r_inv_rd : i_addr;
    assign prod     = (2*PV_W)'(r_r) * (2*PV_W)'(i_cmd.sq ? r_r : r_q);
    assign bonf     = BW'(r_raw_rd) * BW'(i_k);
    assign bonf_sat = (bonf > BW'(Q_ONE)) ? Q_ONE : bonf[PV_W-1:0];

    always_comb begin
        v_run = r_v;
        if (!i_cmd.first) begin
            if (i_cmd.run_max && r_prev > r_v) v_run = r_prev;
            if (i_cmd.run_min && r_prev < r_v) v_run = r_prev;
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) mem_raw[i_addr] <= p_sat;
        r_raw_rd <= mem_raw[raw_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rank_fin) begin
            mem_rank[i_addr] <= r_pos[AW-1:0];
        end else if (r_scan_vld && r_raw_rd > r_p) begin
            mem_rank[r_scan_addr] <= r_rank_rd + 1'b1;
        end
        r_rank_rd <= mem_rank[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_inv_vld) mem_inv[r_rank_rd] <= r_inv_addr;
        r_inv_rd <= mem_inv[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) mem_adj[r_idx] <= v_run;
        r_adj_rd <= mem_adj[i_addr];
    end

    // pipeline tags for scan and inverse build
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_vld <= 1'b0;
            r_inv_vld  <= 1'b0;
        end else begin
            r_scan_vld <= i_cmd.scan_rd;
            r_inv_vld  <= i_cmd.inv_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_addr <= i_addr;
        r_inv_addr  <= i_addr;
        if (i_cmd.load_in) begin
            r_p   <= p_sat;
            r_pos <= '0;
        end else if (r_scan_vld && !(r_raw_rd > r_p)) begin
            r_pos <= r_pos + 1'b1;
        end
        if (i_cmd.idx_load) r_idx <= raw_addr;
        if (i_cmd.init) begin
            r_q <= Q_ONE - r_raw_rd;
            r_r <= Q_ONE;
            r_v <= bonf_sat;
        end
        if (i_cmd.sq || i_cmd.mu) r_r <= prod[2*PV_W-2:PV_W-1];
        if (i_cmd.sidak_fin)      r_v <= Q_ONE - r_r;
        if (i_cmd.wr)             r_prev <= v_run;
    end

    // output register
    assign o_out_free    = !r_out_vld || m_axis_tready;
    assign m_axis_tvalid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            m_axis_tdata <= r_adj_rd;
            m_axis_tlast <= i_cmd.out_last;
            m_axis_tuser <= i_cmd.out_ovf;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> o_out_free) else $error("output overwritten");
    a_sidak_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.sq || i_cmd.mu) |-> (r_r <= Q_ONE)) else $error("power above one");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rank_fin |-> (r_pos <= (AW+1)'(MAX_ITEMS - 1))) else $error("rank too big");
endmodule

>>> tb/tb_top.sv
// Testbench for the p-value adjustment engine: directed table, capacity overflow, then random batches.
`timescale 1ns / 1ps
module tb_top;
    import pvma_pkg::*;

    localparam int unsigned CAP       = DEF_MAX_ITEMS;
    localparam longint      CYCLE_CAP = 3000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] pvalue
    logic        s_axis_tlast = 1'b0; // last_item
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [31:0] adjusted_pvalue
    logic        m_axis_tlast;        // final_result
    logic        m_axis_tuser;        // [0] overflow_flag
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [1:0]  i_cfg_data = '0;

    pvalue_multiple_test_adjust dut (.*);

    // clock: 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    typedef struct packed {
        logic [31:0] pv;
        logic        fin;
        logic        ovf;
    } t_adj;

    // predictor state
    logic [1:0]  mdl_mode;
    logic        mdl_meth;
    logic [31:0] mdl_raw [CAP];
    logic [5:0]  mdl_rank[CAP];
    int unsigned mdl_count;
    logic        mdl_drop;

    t_adj        adj_queue[$];
    int          n_fail;
    int          n_results;
    int          n_batches;
    longint      cycles;

    // truncated Q1.31 product
    function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
        logic [63:0] pr;
        pr = a * b;
        return pr >> 31;
    endfunction

    function automatic logic [63:0] corrected(logic [63:0] p, int unsigned k);
        logic [63:0] r;
        logic [63:0] q;
        if (mdl_meth == METH_BONFERRONI) begin
            r = p * k;
            return (r > {32'd0, Q_ONE}) ? {32'd0, Q_ONE} : r;
        end
        q = {32'd0, Q_ONE} - p;
        r = {32'd0, Q_ONE};
        for (int b = 6; b >= 0; b--) begin
            r = qmul(r, r);
            if ((k >> b) & 1) r = qmul(r, q);
        end
        if (r > {32'd0, Q_ONE}) r = {32'd0, Q_ONE};
        return {32'd0, Q_ONE} - r;
    endfunction

    // insert one p-value and, on the batch end, queue its adjusted values
    task automatic rank_and_adjust(logic [31:0] pin, logic lst);
        logic [31:0] p;
        logic [31:0] adj[CAP];
        logic [63:0] v, run;
        int unsigned n, pos, idx;
        t_adj e;
        p = (pin > Q_ONE) ? Q_ONE : pin;
        if (mdl_count < CAP) begin
            n = mdl_count;
            mdl_raw[n] = p;
            pos = 0;
            for (int i = 0; i < n; i++)
                if (mdl_raw[mdl_rank[i]] <= p) pos++;
            for (int i = n; i > pos; i--) mdl_rank[i] = mdl_rank[i-1];
            mdl_rank[pos] = n[5:0];
            mdl_count = n + 1;
        end else begin
            mdl_drop = 1'b1;
        end
        if (!lst) return;
        n = mdl_count;
        run = 0;
        if (mdl_mode == MODE_STEP_DOWN) begin
            for (int i = 0; i < n; i++) begin
                idx = mdl_rank[i];
                v = corrected(mdl_raw[idx], n - i);
                if (i > 0 && run > v) v = run;
                adj[idx] = v[31:0];
                run = v;
            end
        end else if (mdl_mode == MODE_STEP_UP) begin
            for (int i = n; i > 0; i--) begin
                idx = mdl_rank[i-1];
                v = corrected(mdl_raw[idx], n - (i - 1));
                if (i < n && run < v) v = run;
                adj[idx] = v[31:0];
                run = v;
            end
        end else begin
            for (int i = 0; i < n; i++) adj[i] = 32'(corrected(mdl_raw[i], n));
        end
        for (int i = 0; i < n; i++) begin
            e.pv  = adj[i];
            e.fin = (i + 1 == n);
            e.ovf = mdl_drop;
            adj_queue.push_back(e);
        end
        mdl_count = 0;
        mdl_drop  = 1'b0;
        n_batches++;
    endtask

    // directed rows; a row with chk set also carries the expected value of a
    // one-item batch (a single value under any mode is corrected with k = 1)
    typedef struct {
        logic [31:0] pv;
        logic        lst;
        logic        chk;
        logic [31:0] want;
    } t_row;

    // hold valid low for the drawn gap, then offer the item until it transfers
    task automatic send_one(logic [31:0] pv, logic lst);
        int gap;
        gap = $urandom_range(0, 13);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pv;
        s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
        rank_and_adjust(pv, lst);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (adj_queue.size() != 0) @(negedge i_clk);
        // allow the engine to settle after the final transfer
        repeat (20) @(negedge i_clk);
    endtask

    // write a register only while idle
    task automatic write_reg(logic idx, logic [1:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_IDX_ADJUST_MODE) mdl_mode = val;
        else                            mdl_meth = val[0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_pv();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return Q_ONE;
            2: return $urandom_range(0, 255);
            default: return $urandom_range(0, 32'h8000_0000);
        endcase
    endfunction

    // receiver: random stalls, compare with the oldest expectation
    initial begin
        t_adj e;
        int   hold;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            hold = $urandom_range(0, 13);
            if ($urandom_range(0, 3) == 0) hold = 0;
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            if (adj_queue.size() == 0) begin
                $error("unexpected result pv=%h", m_axis_tdata);
                n_fail++;
            end else begin
                e = adj_queue.pop_front();
                n_results++;
                if (m_axis_tdata !== e.pv) begin
                    $error("adjusted_pvalue exp %h got %h", e.pv, m_axis_tdata);
                    n_fail++;
                end
                if (m_axis_tlast !== e.fin) begin
                    $error("final_result exp %b got %b", e.fin, m_axis_tlast);
                    n_fail++;
                end
                if (m_axis_tuser !== e.ovf) begin
                    $error("overflow_flag exp %b got %b", e.ovf, m_axis_tuser);
                    n_fail++;
                end
            end
        end
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_CAP) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_row rows[$];
        t_row r;
        int   n_items;
        int   len;
        n_fail = 0; n_results = 0; n_batches = 0;
        mdl_mode = MODE_SINGLE; mdl_meth = METH_BONFERRONI;
        mdl_count = 0; mdl_drop = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table: one-item batches at the extremes, then a tie batch
        rows.push_back('{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000});
        rows.push_back('{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000});
        rows.push_back('{32'hFFFF_FFFF, 1'b1, 1'b1, 32'h8000_0000}); // saturates
        rows.push_back('{32'h8000_0001, 1'b1, 1'b1, 32'h8000_0000});
        rows.push_back('{32'h0000_0001, 1'b1, 1'b1, 32'h0000_0001});
        rows.push_back('{32'h1000_0000, 1'b0, 1'b0, 32'h0});
        rows.push_back('{32'h1000_0000, 1'b0, 1'b0, 32'h0});          // tie
        rows.push_back('{32'h0800_0000, 1'b0, 1'b0, 32'h0});
        rows.push_back('{32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0});
        for (int m = 0; m < 4; m++) begin
            for (int c = 0; c < 2; c++) begin
                write_reg(CFG_IDX_ADJUST_MODE, m[1:0]);
                write_reg(CFG_IDX_METHOD, c[1:0]);
                foreach (rows[i]) begin
                    r = rows[i];
                    send_one(r.pv, r.lst);
                    // known values hold in every mode and method
                    if (r.chk && (adj_queue.size() == 0 || adj_queue[$].pv !== r.want))
                    begin
                        $error("table row %0d adjusted_pvalue exp %h got %h", i, r.want,
                               (adj_queue.size() == 0) ? 32'h0 : adj_queue[$].pv);
                        n_fail++;
                    end
                end
            end
        end

        // capacity exceeded twice, each time ended by a dropped item marked last
        write_reg(CFG_IDX_ADJUST_MODE, MODE_STEP_DOWN);
        write_reg(CFG_IDX_METHOD, {1'b0, METH_SIDAK});
        for (int i = 0; i < CAP + 3; i++) send_one(rand_pv(), i == CAP + 2);
        write_reg(CFG_IDX_ADJUST_MODE, MODE_STEP_UP);
        for (int i = 0; i < CAP + 2; i++) send_one(rand_pv(), i == CAP + 1);

        // random batches, mostly short, settings sometimes changed between them
        n_items = 0;
        while (n_items < 125) begin
            if ($urandom_range(0, 2) == 0) begin
                write_reg(CFG_IDX_ADJUST_MODE, 2'($urandom_range(0, 3)));
                write_reg(CFG_IDX_METHOD, 2'($urandom_range(0, 1)));
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 66)
                                              : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) send_one(rand_pv(), i == len - 1);
            n_items += len;
            // hold off until every expected result has arrived
            if ($urandom_range(0, 5) == 0) drain();
        end

        drain();
        $display("Covered %0d batches and %0d results across all modes and methods,",
                 n_batches, n_results);
        $display("including saturation, ties and capacity overflow.");
        if (n_fail == 0 && adj_queue.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
